// File: src/assert_macros.svh
// Assertion macros for the checker module of the address cache.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ARPC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ARPC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`endif

// File: src/arpc_pkg.sv
// Package of the IP-to-MAC address cache: field widths, operation codes,
// controller states and the command/status structs. No dependencies.
`default_nettype none

package arpc_pkg;

  localparam int unsigned IpW    = 32;
  localparam int unsigned MacW   = 48;
  localparam int unsigned TimeW  = 48;
  localparam int unsigned TmoW   = 32;
  localparam int unsigned InDataW  = 128;  // ip, mac, now packed
  localparam int unsigned OutDataW = 48;   // mac_result

  localparam logic [TmoW-1:0] TimeoutReset = 32'd60000;

  typedef enum logic {
    OP_LEARN  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture an input item and restart the scan
    logic scan;    // issue table reads and evaluate returned entries
    logic commit;  // write the learnt mapping into the chosen slot
    logic emit;    // move the result into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;  // last entry evaluated or the scan stopped early
    logic is_learn;   // current item is a learn
    logic out_free;   // output register can take a result this cycle
  } dp_status_t;

endpackage

`default_nettype wire

// File: src/arp_cache_learn_lookup.sv
// One item in flight: a new input item is accepted only after the result
// of the last one has moved into the output register.
// Each item runs an entry scan: one table read per cycle through a
// single registered read port, then a write-back state for a learn.
// A lookup that hits a fresh entry or a learn that matches stops the scan early.
// Reset (rst_ni low, asynchronous) clears all valid bits and sets the timeout to 60000.
`default_nettype none

module arp_cache_learn_lookup import arpc_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input item stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,   // [31:0] ip_addr, [79:32] mac_addr,
                                                   // [127:80] now_ms
  input  wire logic                s_axis_tuser,   // [0] operation
  // result stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,   // [47:0] mac_result
  output logic                     m_axis_tuser,   // [0] found
  // timeout register write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [TmoW-1:0]     cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  arpc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  arpc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_op_i     (s_axis_tuser),
    .in_ip_i     (s_axis_tdata[IpW-1:0]),
    .in_mac_i    (s_axis_tdata[IpW+MacW-1:IpW]),
    .in_now_i    (s_axis_tdata[IpW+MacW+TimeW-1:IpW+MacW]),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_found_o (m_axis_tuser),
    .out_mac_o   (m_axis_tdata)
  );

endmodule

`default_nettype wire

// File: src/arpc_ctrl.sv
// Controller of the address cache: sequences load, scan, write-back and
// result transfer. Depends on arpc_pkg.
`default_nettype none

module arpc_ctrl import arpc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_valid_i,
  output logic            s_ready_o,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) begin
          state_d = status_i.is_learn ? S_WRITE : S_DONE;
        end
      end
      S_WRITE: begin
        cmd_o.commit = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/arpc_datapath.sv
// Datapath of the address cache: item registers, entry tables, valid bits,
// scan trackers, timeout register and output register. Depends on arpc_pkg.
`default_nettype none

module arpc_datapath import arpc_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ctrl_cmd_t           cmd_i,
  output dp_status_t               status_o,
  input  wire logic                in_op_i,
  input  wire logic [IpW-1:0]      in_ip_i,
  input  wire logic [MacW-1:0]     in_mac_i,
  input  wire logic [TimeW-1:0]    in_now_i,
  input  wire logic                cfg_we_i,
  input  wire logic [TmoW-1:0]     cfg_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     out_found_o,
  output logic [MacW-1:0]          out_mac_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  // Entry tables
  logic [IpW-1:0]   ip_mem    [ENTRIES];
  logic [MacW-1:0]  mac_mem   [ENTRIES];
  logic [TimeW-1:0] stamp_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_q;

  // Item and configuration
  logic [TmoW-1:0]  timeout_q;
  logic             op_q;
  logic [IpW-1:0]   ip_q;
  logic [MacW-1:0]  mac_q;
  logic [TimeW-1:0] now_q;

  // Scan pipeline
  logic [IdxW-1:0]  rd_ptr_q;
  logic             issue_q;
  logic [IdxW-1:0]  eval_ptr_q;
  logic             eval_vld_q;
  logic [IpW-1:0]   rd_ip_q;
  logic [MacW-1:0]  rd_mac_q;
  logic [TimeW-1:0] rd_stamp_q;

  // Trackers
  logic             match_q, inv_q, min_vld_q, found_q;
  logic [IdxW-1:0]  match_idx_q, inv_idx_q, min_idx_q;
  logic [TimeW-1:0] min_stamp_q;
  logic [MacW-1:0]  hit_mac_q;

  // Output register
  logic             out_valid_q, out_found_q;
  logic [MacW-1:0]  out_mac_q;

  logic             ent_valid, ent_hit, fresh, stop, older;
  logic [TimeW:0]   age;
  logic [IdxW-1:0]  tgt_idx;

  // Evaluate the entry returned by the table read
  always_comb begin
    ent_valid = valid_q[eval_ptr_q];
    ent_hit   = eval_vld_q && ent_valid && (rd_ip_q == ip_q);
    age       = {1'b0, now_q} - {1'b0, rd_stamp_q};
    fresh     = !age[TimeW] && (age[TimeW-1:0] < {{(TimeW-TmoW){1'b0}}, timeout_q});
    stop      = ent_hit && ((op_q == OP_LEARN) || fresh);
    older     = rd_stamp_q < min_stamp_q;
    tgt_idx   = match_q ? match_idx_q : (inv_q ? inv_idx_q : min_idx_q);
  end

  assign status_o.scan_done = eval_vld_q && (stop || (eval_ptr_q == LastIdx));
  assign status_o.is_learn  = (op_q == OP_LEARN);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // Control state: valid bits, scan flags, trackers, output valid, timeout
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      timeout_q   <= TimeoutReset;
      rd_ptr_q    <= '0;
      issue_q     <= 1'b0;
      eval_vld_q  <= 1'b0;
      match_q     <= 1'b0;
      inv_q       <= 1'b0;
      min_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        rd_ptr_q   <= '0;
        issue_q    <= 1'b1;
        eval_vld_q <= 1'b0;
        match_q    <= 1'b0;
        inv_q      <= 1'b0;
        min_vld_q  <= 1'b0;
        found_q    <= 1'b0;
      end
      if (cmd_i.scan) begin
        // advance the read pointer
        if (issue_q) begin
          rd_ptr_q   <= rd_ptr_q + 1'b1;
          issue_q    <= (rd_ptr_q != LastIdx);
          eval_vld_q <= 1'b1;
        end else begin
          eval_vld_q <= 1'b0;
        end
        // track the outcome of the returned entry
        if (eval_vld_q) begin
          if (op_q == OP_LOOKUP) begin
            if (ent_hit && fresh) begin
              found_q <= 1'b1;
            end else if (ent_hit) begin
              valid_q[eval_ptr_q] <= 1'b0;
            end
          end else begin
            if (ent_hit && !match_q) begin
              match_q <= 1'b1;
            end
            if (!ent_valid && !inv_q) begin
              inv_q <= 1'b1;
            end
            if (ent_valid) begin
              min_vld_q <= 1'b1;
            end
          end
        end
      end
      if (cmd_i.commit) begin
        valid_q[tgt_idx] <= 1'b1;
      end
      // hold the result until transferred
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_op_i;
      ip_q  <= in_ip_i;
      mac_q <= in_mac_i;
      now_q <= in_now_i;
    end
    if (cmd_i.scan) begin
      if (issue_q) begin
        eval_ptr_q <= rd_ptr_q;
      end
      if (eval_vld_q) begin
        if (op_q == OP_LOOKUP) begin
          if (ent_hit && fresh) begin
            hit_mac_q <= rd_mac_q;
          end
        end else begin
          if (ent_hit && !match_q) begin
            match_idx_q <= eval_ptr_q;
          end
          if (!ent_valid && !inv_q) begin
            inv_idx_q <= eval_ptr_q;
          end
          if (ent_valid && (!min_vld_q || older)) begin
            min_stamp_q <= rd_stamp_q;
            min_idx_q   <= eval_ptr_q;
          end
        end
      end
    end
    if (cmd_i.emit) begin
      out_found_q <= found_q;
      out_mac_q   <= found_q ? hit_mac_q : '0;
    end
  end

  // Table read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && issue_q) begin
      rd_ip_q    <= ip_mem[rd_ptr_q];
      rd_mac_q   <= mac_mem[rd_ptr_q];
      rd_stamp_q <= stamp_mem[rd_ptr_q];
    end
  end

  // Table write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      ip_mem[tgt_idx]    <= ip_q;
      mac_mem[tgt_idx]   <= mac_q;
      stamp_mem[tgt_idx] <= now_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_found_o = out_found_q;
  assign out_mac_o   = out_mac_q;

endmodule

`default_nettype wire

// File: src/arpc_checker.sv
// Port-level checker of the address cache, bound to the top level.
// Depends on arpc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module arpc_checker import arpc_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic [InDataW-1:0]  s_axis_tdata,
  input wire logic                s_axis_tuser,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata,
  input wire logic                m_axis_tuser,
  input wire logic                cfg_valid_i,
  input wire logic                cfg_ready_o,
  input wire logic [TmoW-1:0]     cfg_data_i
);

  // A stalled result holds its payload
  `ARPC_ASSERT(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "result changed while stalled")

  // A miss or a learn carries a zero address
  `ARPC_ASSERT_NEVER(a_miss_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser && (m_axis_tdata != '0), "miss with non-zero address")

  // Input stays blocked as the scan of an accepted item starts
  `ARPC_ASSERT(a_busy_scan, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> (!s_axis_tready ##1 !s_axis_tready), "input accepted during scan")

  // Configuration port never back-pressures
  `ARPC_ASSERT(a_cfg_ready, clk_i, rst_ni, cfg_valid_i |-> cfg_ready_o, "configuration write stalled")

endmodule

bind arp_cache_learn_lookup arpc_checker u_arpc_checker (.*);

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking bench for the IP-to-MAC address cache: directed rows, then random
// learn/lookup traffic over several timeout settings, checked against a cache predictor.
// Depends on arpc_pkg and arp_cache_learn_lookup.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import arpc_pkg::*;

  localparam int unsigned ENTRIES     = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned POOL_SIZE   = 20;
  localparam int unsigned PHASE_ITEMS = 110;
  localparam int unsigned NUM_PHASES  = 5;

  typedef struct packed {
    logic            found;
    logic [MacW-1:0] mac;
  } lookup_res_t;

  typedef struct {
    op_e              op;
    logic [IpW-1:0]   ip;
    logic [MacW-1:0]  mac;
    logic [TimeW-1:0] now_ms;
    bit               typed;
    lookup_res_t      want;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // [31:0] ip_addr, [79:32] mac_addr, [127:80] now_ms
  logic                s_axis_tuser;   // [0] operation
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // [47:0] mac_result
  logic                m_axis_tuser;   // [0] found
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [TmoW-1:0]     cfg_data_i;

  // Shadow copy of the cache and its timeout register
  logic              shadow_valid [ENTRIES];
  logic [IpW-1:0]    shadow_ip    [ENTRIES];
  logic [MacW-1:0]   shadow_mac   [ENTRIES];
  logic [TimeW-1:0]  shadow_stamp [ENTRIES];
  logic [TmoW-1:0]   shadow_timeout;

  lookup_res_t       pending_results [$];
  stim_row_t         directed_rows [$];
  logic [IpW-1:0]    ip_pool [POOL_SIZE];
  logic [TimeW-1:0]  time_ms;
  int unsigned       fail_count;
  int unsigned       cycle_count;
  int                send_quiet;
  int                recv_quiet;

  arp_cache_learn_lookup #(.ENTRIES(ENTRIES)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Apply one item to the shadow cache and return the result it should give
  function automatic lookup_res_t predict_cache(op_e op, logic [IpW-1:0] ip,
                                                logic [MacW-1:0] mac,
                                                logic [TimeW-1:0] now_ms);
    lookup_res_t      res;
    bit               done;
    bit               have_min;
    bit               free_seen;
    int               pick;
    logic [TimeW-1:0] min_stamp;
    res       = '0;
    done      = 1'b0;
    have_min  = 1'b0;
    free_seen = 1'b0;
    pick      = 0;
    min_stamp = '0;
    if (op == OP_LEARN) begin
      // Refresh the first valid match
      for (int s = 0; s < ENTRIES; s++) begin
        if (!done && shadow_valid[s] && shadow_ip[s] == ip) begin
          shadow_mac[s]   = mac;
          shadow_stamp[s] = now_ms;
          done = 1'b1;
        end
      end
      // Otherwise take the first free slot, else the oldest (lowest index on ties)
      if (!done) begin
        for (int s = 0; s < ENTRIES; s++) begin
          if (!free_seen) begin
            if (!shadow_valid[s]) begin
              pick      = s;
              free_seen = 1'b1;
            end else if (!have_min || shadow_stamp[s] < min_stamp) begin
              have_min  = 1'b1;
              min_stamp = shadow_stamp[s];
              pick      = s;
            end
          end
        end
        shadow_ip[pick]    = ip;
        shadow_mac[pick]   = mac;
        shadow_stamp[pick] = now_ms;
        shadow_valid[pick] = 1'b1;
      end
    end else begin
      // Drop stale matches until the first fresh one
      for (int s = 0; s < ENTRIES; s++) begin
        if (!res.found && shadow_valid[s] && shadow_ip[s] == ip) begin
          if (now_ms >= shadow_stamp[s] &&
              (now_ms - shadow_stamp[s]) < TimeW'(shadow_timeout)) begin
            res.found = 1'b1;
            res.mac   = shadow_mac[s];
          end else begin
            shadow_valid[s] = 1'b0;
          end
        end
      end
    end
    return res;
  endfunction

  function automatic void add_row(op_e op, logic [IpW-1:0] ip, logic [MacW-1:0] mac,
                                  logic [TimeW-1:0] now_ms, bit typed,
                                  logic found, logic [MacW-1:0] want_mac);
    stim_row_t row;
    row.op         = op;
    row.ip         = ip;
    row.mac        = mac;
    row.now_ms     = now_ms;
    row.typed      = typed;
    row.want.found = found;
    row.want.mac   = want_mac;
    directed_rows.push_back(row);
  endfunction

  // Drive one item from a falling edge and hold it until the transfer
  task automatic send_item(input stim_row_t row);
    int          gap;
    lookup_res_t res;
    if (send_quiet > 0) begin
      gap = 0;
      send_quiet--;
    end else begin
      gap = $urandom_range(0, 14);
      if ($urandom_range(0, 19) == 0) send_quiet = $urandom_range(5, 25);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {row.now_ms, row.mac, row.ip};
    s_axis_tuser  <= row.op;
    do @(posedge clk_i); while (!s_axis_tready);
    res = predict_cache(row.op, row.ip, row.mac, row.now_ms);
    if (row.typed) res = row.want;
    pending_results.push_back(res);
    @(negedge clk_i);
  endtask

  // Advance the time base: mostly short steps, some around the timeout edge,
  // some backwards and some anywhere in the 48-bit range
  task automatic send_random_item();
    stim_row_t   row;
    logic [63:0] span;
    logic [63:0] t;
    int unsigned sel;
    span = {32'b0, shadow_timeout} / 4 + 1;
    sel  = $urandom_range(0, 99);
    if (sel < 75)      t = 64'(time_ms) + $urandom_range(0, 32'(span - 1));
    else if (sel < 85) t = 64'(time_ms) + shadow_timeout - 1 + $urandom_range(0, 2);
    else if (sel < 93) t = 64'(time_ms) - $urandom_range(0, 32'(span));
    else               t = {$urandom, $urandom};
    time_ms    = t[TimeW-1:0];
    row.op     = ($urandom_range(0, 99) < 55) ? OP_LOOKUP : OP_LEARN;
    row.ip     = ($urandom_range(0, 9) == 0) ? IpW'($urandom)
                                             : ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    t          = {$urandom, $urandom};
    row.mac    = t[MacW-1:0];
    row.now_ms = time_ms;
    row.typed  = 1'b0;
    row.want   = '0;
    send_item(row);
  endtask

  // Hold off until every issued item has returned its result
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_timeout(input logic [TmoW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_timeout = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Main sequence
  initial begin
    logic [TmoW-1:0] phase_timeout [NUM_PHASES];
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    fail_count    = 0;
    send_quiet    = 0;
    time_ms       = '0;
    shadow_timeout = TimeoutReset;
    for (int s = 0; s < ENTRIES; s++) begin
      shadow_valid[s] = 1'b0;
      shadow_ip[s]    = '0;
      shadow_mac[s]   = '0;
      shadow_stamp[s] = '0;
    end

    // Directed rows; the default timeout of 60000 applies
    add_row(OP_LOOKUP, 32'h0000_0000, '0, 48'd0, 1, 1'b0, '0);      // empty cache
    add_row(OP_LEARN,  32'h0A00_0001, '0, 48'd1000, 1, 1'b0, '0);
    add_row(OP_LOOKUP, 32'h0A00_0001, '0, 48'd1000, 1, 1'b1, '0);   // age zero
    add_row(OP_LEARN,  32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'd100, 1, 1'b0, '0);
    add_row(OP_LOOKUP, 32'hFFFF_FFFF, '0, 48'd60099, 1, 1'b1, 48'hFFFF_FFFF_FFFF);
    add_row(OP_LOOKUP, 32'hFFFF_FFFF, '0, 48'd60100, 1, 1'b0, '0);  // age equals timeout
    add_row(OP_LOOKUP, 32'h0A00_0001, '0, 48'd999, 1, 1'b0, '0);    // clock went backwards
    // Fill every slot; slots 5 and 9 share the oldest stamp
    for (int k = 0; k < ENTRIES; k++)
      add_row(OP_LEARN, 32'hC0A8_0100 + k, {16'hA5A5, 32'(k)},
              (k == 5 || k == 9) ? 48'd2000 : 48'd2100 + 7 * k, 1, 1'b0, '0);
    // Full cache: evict the lower of the tied oldest slots
    add_row(OP_LEARN,  32'h0000_0000, 48'h1234_5678_9ABC, 48'hFFFF_FFFF_FFFF, 1, 1'b0, '0);
    add_row(OP_LOOKUP, 32'h0000_0000, '0, 48'hFFFF_FFFF_FFFF, 1, 1'b1, 48'h1234_5678_9ABC);
    add_row(OP_LOOKUP, 32'hC0A8_0105, '0, 48'd2200, 0, 1'b0, '0);
    add_row(OP_LOOKUP, 32'hC0A8_0109, '0, 48'd2200, 0, 1'b0, '0);

    phase_timeout[0] = 32'hFFFF_FFFF;
    phase_timeout[1] = 32'd1;
    phase_timeout[2] = $urandom_range(50, 5000);
    phase_timeout[3] = TimeoutReset;
    phase_timeout[4] = $urandom_range(1, 32'hFFFF_FFFF);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) send_item(directed_rows[i]);
    time_ms = 48'd5000;

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_timeout(phase_timeout[p]);
      for (int k = 0; k < POOL_SIZE; k++) ip_pool[k] = $urandom;
      repeat (PHASE_ITEMS) send_random_item();
    end

    // Drain, then allow the block's latency to pass for stray results
    wait_idle();
    repeat (ENTRIES + 4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Result side: random stalls, compare each transfer with the oldest expectation
  initial begin
    int          stall;
    lookup_res_t got;
    lookup_res_t want;
    m_axis_tready = 1'b0;
    recv_quiet    = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (recv_quiet > 0) begin
        stall = 0;
        recv_quiet--;
      end else begin
        stall = $urandom_range(0, 14);
        if ($urandom_range(0, 19) == 0) recv_quiet = $urandom_range(5, 25);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.found = m_axis_tuser;
      got.mac   = m_axis_tdata;
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual found=%0b mac=%h",
                 $time, got.found, got.mac);
      end else begin
        want = pending_results.pop_front();
        if (got.found !== want.found) begin
          fail_count++;
          $display("%0t: found mismatch, expected %0b, actual %0b",
                   $time, want.found, got.found);
        end
        if (got.mac !== want.mac) begin
          fail_count++;
          $display("%0t: mac_result mismatch, expected %h, actual %h",
                   $time, want.mac, got.mac);
        end
      end
    end
  end

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

// File: files.f
+incdir+src
src/arpc_pkg.sv
src/arpc_ctrl.sv
src/arpc_datapath.sv
src/arp_cache_learn_lookup.sv
src/arpc_checker.sv
tb/tb_top.sv
